/* sv/assert_macros.svh */
// Shared assertion macros for the edit-distance core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every rising edge outside reset.
`define LED_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("led assertion failed");

// Condition that must never hold outside reset.
`define LED_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("led forbidden condition seen");

`else

`define LED_ASSERT(lbl, clk, rstn, prop)
`define LED_NEVER(lbl, clk, rstn, cond)

`endif

`endif

/* sv/led_pkg.sv */
package led_pkg;

    localparam int MAX_QUERY    = 16;
    localparam int MAX_DISTANCE = 127;

    localparam int DIST_W    = $clog2(MAX_DISTANCE + 1);
    localparam int LEN_W     = $clog2(MAX_QUERY + 1);
    localparam int QLEN_W    = 5;
    localparam int OUT_W     = 7;
    localparam int CHAR_W    = 8;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int QCHARS    = 16;

    localparam logic [DIST_W:0] MAXD_EXT = (DIST_W + 1)'(MAX_DISTANCE);

    localparam logic [CFG_IDX_W-1:0] REG_QUERY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_LEN  = 2'd2;

    // one candidate byte travelling down the cell row
    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              empty;
        logic [DIST_W-1:0] left;   // new value of the cell to the left
        logic [DIST_W-1:0] diag;   // previous-row value of the cell to the left
        logic              flag;   // saturation seen on this row
        logic [DIST_W-1:0] res;    // value of the cell at the query length
    } tok_t;

    function automatic logic [DIST_W-1:0] cell_init(input int j);
        cell_init = (j > MAX_DISTANCE) ? DIST_W'(MAX_DISTANCE) : DIST_W'(j);
    endfunction

endpackage

/* sv/led_head.sv */
`include "assert_macros.svh"

module led_head
    import led_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  tok_t tok_in,
    output tok_t tok_out
);

    logic [DIST_W-1:0] row_reg;
    logic [DIST_W-1:0] row_next;
    logic [DIST_W:0]   n_raw;
    logic [DIST_W-1:0] n;
    logic              clip;
    tok_t              tok_reg;
    tok_t              tok_next;

    always_comb
    begin
        n_raw    = {1'b0, row_reg} + (DIST_W + 1)'(1);
        clip     = n_raw > MAXD_EXT;
        n        = clip ? DIST_W'(MAX_DISTANCE) : n_raw[DIST_W-1:0];
        tok_next = tok_in;
        row_next = row_reg;
        if (tok_in.empty)
        begin
            tok_next.left = '0;
            tok_next.diag = '0;
            tok_next.flag = 1'b0;
            tok_next.res  = '0;
        end
        else
        begin
            tok_next.left = n;
            tok_next.diag = row_reg;
            tok_next.flag = clip;
            tok_next.res  = n;
        end
        if (tok_in.valid)
        begin
            row_next = (tok_in.empty || tok_in.last) ? '0 : n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            tok_reg <= '0;
        end
        else if (adv)
        begin
            row_reg <= row_next;
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

    `LED_ASSERT(a_head_restart, clk, rst_n,
        (adv && tok_in.valid && (tok_in.last || tok_in.empty)) |=> (row_reg == '0))
    `LED_NEVER(a_head_range, clk, rst_n, {1'b0, row_reg} > MAXD_EXT)

endmodule

/* sv/led_cell.sv */
`include "assert_macros.svh"

module led_cell
    import led_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  tok_t              tok_in,
    input  logic [CHAR_W-1:0] qch,
    input  logic [DIST_W-1:0] rst_val,
    input  logic              used,
    input  logic              take,
    output tok_t              tok_out
);

    logic [DIST_W-1:0] cell_reg;
    logic [DIST_W-1:0] cell_next;
    tok_t              tok_reg;
    tok_t              tok_next;
    logic [DIST_W:0]   ins;
    logic [DIST_W:0]   del;
    logic [DIST_W:0]   sub;
    logic [DIST_W:0]   m_raw;
    logic [DIST_W-1:0] m;
    logic              clip;

    always_comb
    begin
        ins   = {1'b0, cell_reg} + (DIST_W + 1)'(1);
        del   = {1'b0, tok_in.left} + (DIST_W + 1)'(1);
        sub   = {1'b0, tok_in.diag} + {DIST_W'(0), (tok_in.ch != qch)};
        m_raw = (ins < del) ? ins : del;
        if (sub < m_raw)
        begin
            m_raw = sub;
        end
        clip = m_raw > MAXD_EXT;
        m    = clip ? DIST_W'(MAX_DISTANCE) : m_raw[DIST_W-1:0];

        tok_next  = tok_in;
        cell_next = cell_reg;
        if (tok_in.valid)
        begin
            if (tok_in.empty)
            begin
                cell_next = rst_val;
            end
            else
            begin
                tok_next.left = m;
                tok_next.diag = cell_reg;
                tok_next.flag = tok_in.flag | (clip & used);
                if (take)
                begin
                    tok_next.res = m;
                end
                cell_next = tok_in.last ? rst_val : m;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= rst_val;
            tok_reg  <= '0;
        end
        else if (adv)
        begin
            cell_reg <= cell_next;
            tok_reg  <= tok_next;
        end
    end

    assign tok_out = tok_reg;

    `LED_ASSERT(a_cell_restart, clk, rst_n,
        (adv && tok_in.valid && (tok_in.last || tok_in.empty)) |=> (cell_reg == $past(rst_val)))
    `LED_NEVER(a_cell_range, clk, rst_n, {1'b0, cell_reg} > MAXD_EXT)

endmodule

/* sv/led_tail.sv */
`include "assert_macros.svh"

module led_tail
    import led_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  tok_t             tok_in,
    input  logic [LEN_W-1:0] eff_len,
    input  logic             res_ready,
    output logic             adv,
    output logic             res_valid,
    output logic [OUT_W-1:0] distance,
    output logic             saturated
);

    logic                    valid_reg;
    logic                    valid_next;
    logic [OUT_W-1:0]        dist_reg;
    logic [OUT_W-1:0]        dist_next;
    logic                    sat_reg;
    logic                    sat_next;
    logic                    acc_reg;
    logic                    acc_next;
    logic [OUT_W+DIST_W-1:0] res_wide;
    logic [OUT_W+LEN_W-1:0]  len_wide;

    assign adv = !valid_reg || res_ready;

    always_comb
    begin
        res_wide   = {OUT_W'(0), tok_in.res};
        len_wide   = {OUT_W'(0), eff_len};
        valid_next = 1'b0;
        dist_next  = dist_reg;
        sat_next   = sat_reg;
        acc_next   = acc_reg;
        if (tok_in.valid)
        begin
            if (tok_in.empty)
            begin
                valid_next = 1'b1;
                dist_next  = len_wide[OUT_W-1:0];
                sat_next   = 1'b0;
                acc_next   = 1'b0;
            end
            else if (tok_in.last)
            begin
                valid_next = 1'b1;
                dist_next  = res_wide[OUT_W-1:0];
                sat_next   = acc_reg | tok_in.flag;
                acc_next   = 1'b0;
            end
            else
            begin
                acc_next = acc_reg | tok_in.flag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            acc_reg   <= 1'b0;
            dist_reg  <= '0;
            sat_reg   <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
            acc_reg   <= acc_next;
            dist_reg  <= dist_next;
            sat_reg   <= sat_next;
        end
    end

    assign res_valid = valid_reg;
    assign distance  = dist_reg;
    assign saturated = sat_reg;

    `LED_ASSERT(a_tail_empty, clk, rst_n,
        (adv && tok_in.valid && tok_in.empty) |=> (res_valid && !saturated && !acc_reg))
    `LED_ASSERT(a_tail_quiet, clk, rst_n,
        (adv && tok_in.valid && !tok_in.empty && !tok_in.last) |=> !res_valid)

endmodule

/* sv/levenshtein_edit_distance_core.sv */
// Channel   Handshake               Payload
// cand      cand_valid/cand_ready   candidate_char, last_char, empty_word
// res       res_valid/res_ready     distance, saturated
// cfg       cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One candidate byte is taken per cycle while the row advances; each byte
// walks the row of MAX_QUERY cells one cell per cycle, and the result for
// its word is registered in the output stage.
// A held result freezes the whole cell row; cand_ready follows it.
// cfg_ready is low while any item is still in the row or the output stage.
// Reset loads the row with 0..N directly, no clearing pass.
module levenshtein_edit_distance_core
    import led_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cand_valid,
    output logic                 cand_ready,
    input  logic [CHAR_W-1:0]    candidate_char,
    input  logic                 last_char,
    input  logic                 empty_word,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic [OUT_W-1:0]     distance,
    output logic                 saturated,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [CFG_W-1:0]         qlow_reg;
    logic [CFG_W-1:0]         qhigh_reg;
    logic [QLEN_W-1:0]        qlen_reg;
    logic [2*CFG_W-1:0]       qbytes;
    logic [QLEN_W+LEN_W-1:0]  qlen_ext;
    logic [LEN_W-1:0]         eff_len;
    logic                     adv;
    logic                     busy;
    tok_t                     cand_tok;
    tok_t                     chain [0:MAX_QUERY];
    logic [MAX_QUERY:0]       chain_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlow_reg  <= '0;
            qhigh_reg <= '0;
            qlen_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_QUERY_LOW:  qlow_reg  <= cfg_data;
                REG_QUERY_HIGH: qhigh_reg <= cfg_data;
                REG_QUERY_LEN:  qlen_reg  <= cfg_data[QLEN_W-1:0];
                default:        ;
            endcase
        end
    end

    assign qbytes   = {qhigh_reg, qlow_reg};
    assign qlen_ext = {LEN_W'(0), qlen_reg};
    assign eff_len  = (qlen_ext > (QLEN_W + LEN_W)'(MAX_QUERY)) ? LEN_W'(MAX_QUERY)
                                                                : qlen_ext[LEN_W-1:0];

    always_comb
    begin
        cand_tok       = '0;
        cand_tok.valid = cand_valid;
        cand_tok.ch    = candidate_char;
        cand_tok.last  = last_char;
        cand_tok.empty = empty_word;
    end

    assign cand_ready = adv;

    led_head u_head (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .tok_in  (cand_tok),
        .tok_out (chain[0])
    );

    for (genvar j = 1; j <= MAX_QUERY; j++)
    begin : g_cell
        logic [CHAR_W-1:0] qch;
        if (j - 1 < QCHARS)
        begin : g_q
            assign qch = qbytes[CHAR_W*(j-1) +: CHAR_W];
        end
        else
        begin : g_z
            assign qch = '0;
        end

        led_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .tok_in  (chain[j-1]),
            .qch     (qch),
            .rst_val (cell_init(j)),
            .used    (eff_len >= LEN_W'(j)),
            .take    (eff_len == LEN_W'(j)),
            .tok_out (chain[j])
        );
    end

    for (genvar k = 0; k <= MAX_QUERY; k++)
    begin : g_busy
        assign chain_valid[k] = chain[k].valid;
    end

    assign busy      = (|chain_valid) || res_valid;
    assign cfg_ready = !busy;

    led_tail u_tail (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_in    (chain[MAX_QUERY]),
        .eff_len   (eff_len),
        .res_ready (res_ready),
        .adv       (adv),
        .res_valid (res_valid),
        .distance  (distance),
        .saturated (saturated)
    );

endmodule
